/* rtl/pfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants of the fixed-priority FIFO task dispatcher.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int TASK_SLOTS_DEF      = 16;
  localparam int PRIORITY_LEVELS_DEF = 7;
  localparam int INIT_SLOT           = 1;
  localparam int INIT_PRIORITY       = 6;

  typedef enum logic [2:0] {
    ST_EMPTY      = 3'd0,
    ST_RUNNING    = 3'd1,
    ST_READY      = 3'd2,
    ST_BLOCKED    = 3'd3,
    ST_TERMINATED = 3'd4
  } slot_state_t;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_WAKE  = 3'd1,
    OP_BLOCK = 3'd2,
    OP_QUIT  = 3'd3,
    OP_TICK  = 3'd4,
    OP_REAP  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_SLOT_BUSY = 2'd1,
    STS_BAD_STATE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_SEL,
    S_DEQ,
    S_PRE,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] task_req;
    logic [2:0] priority_req;
  } req_t;

  typedef struct packed {
    logic       switched;
    logic [3:0] running_task;
    logic       idle;
    logic [1:0] status;
  } rsp_t;

endpackage
`default_nettype wire

/* rtl/pfd_slot_tbl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_slot_tbl
// Task slot table: state and priority per slot, one read and one write port,
// registered read data. Per-entry valid bits supply the reset contents.
// ----------------------------------------------------------------------------
module pfd_slot_tbl #(
  parameter int TASK_SLOTS      = pfd_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = pfd_pkg::PRIORITY_LEVELS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    rd_en,
  input  wire logic [$clog2(TASK_SLOTS)-1:0]           rd_addr,
  output pfd_pkg::slot_state_t                         rd_state,
  output logic      [$clog2(PRIORITY_LEVELS+1)-1:0]    rd_prio,
  input  wire logic                                    wr_en,
  input  wire logic [$clog2(TASK_SLOTS)-1:0]           wr_addr,
  input  wire pfd_pkg::slot_state_t                    wr_state,
  input  wire logic [$clog2(PRIORITY_LEVELS+1)-1:0]    wr_prio
);

  localparam int SW        = $clog2(TASK_SLOTS);
  localparam int PW        = $clog2(PRIORITY_LEVELS + 1);
  localparam int INIT_PRIO = (PRIORITY_LEVELS < pfd_pkg::INIT_PRIORITY) ?
                             PRIORITY_LEVELS : pfd_pkg::INIT_PRIORITY;

  pfd_pkg::slot_state_t state_mem [TASK_SLOTS];
  logic [PW-1:0]        prio_mem  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld_r;

  pfd_pkg::slot_state_t st_q_r;
  logic [PW-1:0]        pr_q_r;
  logic                 vld_q_r;
  logic                 init_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[wr_addr] <= wr_state;
      prio_mem[wr_addr]  <= wr_prio;
    end
    if (rd_en) begin
      st_q_r   <= state_mem[rd_addr];
      pr_q_r   <= prio_mem[rd_addr];
      vld_q_r  <= vld_r[rd_addr];
      init_q_r <= (rd_addr == SW'(pfd_pkg::INIT_SLOT));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    if (vld_q_r) begin
      rd_state = st_q_r;
      rd_prio  = pr_q_r;
    end else if (init_q_r) begin
      rd_state = pfd_pkg::ST_RUNNING;
      rd_prio  = PW'(INIT_PRIO);
    end else begin
      rd_state = pfd_pkg::ST_EMPTY;
      rd_prio  = '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/pfd_link_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_link_ram
// Next-slot links of the ready queues, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfd_link_ram #(
  parameter int TASK_SLOTS = pfd_pkg::TASK_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(TASK_SLOTS)-1:0] wr_addr,
  input  wire logic [$clog2(TASK_SLOTS)-1:0] wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(TASK_SLOTS)-1:0] rd_addr,
  output logic      [$clog2(TASK_SLOTS)-1:0] rd_data
);

  localparam int SW = $clog2(TASK_SLOTS);

  logic [SW-1:0] link_mem [TASK_SLOTS];
  logic [SW-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= link_mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule
`default_nettype wire

/* rtl/pfd_queues.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_queues
// Head, tail and nonempty flag of each ready queue level.
// ----------------------------------------------------------------------------
module pfd_queues #(
  parameter int TASK_SLOTS      = pfd_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = pfd_pkg::PRIORITY_LEVELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [$clog2(PRIORITY_LEVELS)-1:0]  rd_lv,
  output logic      [$clog2(TASK_SLOTS)-1:0]       head_rd,
  output logic      [$clog2(TASK_SLOTS)-1:0]       tail_rd,
  output logic      [PRIORITY_LEVELS-1:0]          nonempty,
  input  wire logic                                enq_en,
  input  wire logic [$clog2(PRIORITY_LEVELS)-1:0]  enq_lv,
  input  wire logic [$clog2(TASK_SLOTS)-1:0]       enq_slot,
  input  wire logic                                deq_en,
  input  wire logic [$clog2(PRIORITY_LEVELS)-1:0]  deq_lv,
  input  wire logic                                deq_last,
  input  wire logic [$clog2(TASK_SLOTS)-1:0]       deq_next
);

  localparam int SW = $clog2(TASK_SLOTS);

  logic [SW-1:0]              head_r [PRIORITY_LEVELS];
  logic [SW-1:0]              tail_r [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] ne_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r <= '0;
    end else begin
      if (enq_en) begin
        ne_r[enq_lv] <= 1'b1;
      end
      if (deq_en && deq_last) begin
        ne_r[deq_lv] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq_en) begin
      if (!ne_r[enq_lv]) begin
        head_r[enq_lv] <= enq_slot;
      end
      tail_r[enq_lv] <= enq_slot;
    end
    if (deq_en && !deq_last) begin
      head_r[deq_lv] <= deq_next;
    end
  end

  assign head_rd  = head_r[rd_lv];
  assign tail_rd  = tail_r[rd_lv];
  assign nonempty = ne_r;

endmodule
`default_nettype wire

/* rtl/priority_fifo_task_dispatcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_fifo_task_dispatcher
// Fixed-priority FIFO task scheduler: slot table and queue links in
// synchronous memories, a sequencer that applies one event and then the
// dispatch rule.
//
//   channel | ports                         | payload
//   --------+-------------------------------+-----------------
//   request | in_valid, in_stall, in_req    | pfd_pkg::req_t
//   result  | out_valid, out_stall, out_rsp | pfd_pkg::rsp_t
//
// After a request is accepted, the table read and the dispatch choice follow;
// a dispatch adds the dequeue and a preemption the requeue before the result
// is registered. One request is in flight at a time, so a new request is
// not taken while the last one is still in progress.
// Reset is synchronous; slot 1 runs at priority 6 and all queues are empty.
// A held result stalls only the final step; the next request is taken once
// the result register is loaded.
// ----------------------------------------------------------------------------
module priority_fifo_task_dispatcher #(
  parameter int TASK_SLOTS      = pfd_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = pfd_pkg::PRIORITY_LEVELS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire pfd_pkg::req_t in_req,
  output logic         out_valid,
  input  wire logic    out_stall,
  output pfd_pkg::rsp_t out_rsp
);

  localparam int SW        = $clog2(TASK_SLOTS);
  localparam int LW        = $clog2(PRIORITY_LEVELS);
  localparam int PW        = $clog2(PRIORITY_LEVELS + 1);
  localparam int INIT_PRIO = (PRIORITY_LEVELS < pfd_pkg::INIT_PRIORITY) ?
                             PRIORITY_LEVELS : pfd_pkg::INIT_PRIORITY;

  function automatic logic [SW-1:0] slot_of(input logic [3:0] v);
    logic [4:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= TASK_SLOTS) r = r - 5'(TASK_SLOTS);
    end
    return SW'(r);
  endfunction

  function automatic logic [PW-1:0] clamp_prio(input logic [2:0] p);
    logic [4:0] q;
    q = {2'b00, p};
    if (q == 5'd0) q = 5'd1;
    if (q > PRIORITY_LEVELS) q = 5'(PRIORITY_LEVELS);
    return PW'(q);
  endfunction

  function automatic logic [LW-1:0] level_of(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    q = p;
    if (q == '0) q = PW'(1);
    if (q > PRIORITY_LEVELS) q = PW'(PRIORITY_LEVELS);
    return LW'(q - 1'b1);
  endfunction

  pfd_pkg::fsm_t        state_r, state_nxt;
  logic [2:0]           op_r;
  logic [SW-1:0]        slot_r;
  logic [PW-1:0]        prio_r;
  logic [SW-1:0]        before_r;
  logic [SW-1:0]        cur_r;
  pfd_pkg::slot_state_t cur_state_r;
  logic [PW-1:0]        cur_prio_r;
  pfd_pkg::status_t     status_r, status_nxt;
  logic [LW-1:0]        deq_lv_r;
  logic [SW-1:0]        deq_slot_r;
  logic                 deq_last_r;
  logic [SW-1:0]        pre_slot_r;
  logic [PW-1:0]        pre_prio_r;
  logic                 preempt_r;
  logic                 out_valid_r;
  pfd_pkg::rsp_t        out_rsp_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 cur_running;
  logic [LW-1:0]        cur_lvl;
  logic [LW-1:0]        pre_lv;
  logic [LW-1:0]        best_lv;
  logic                 q_any;
  logic                 sel_found;

  logic                 tbl_rd_en;
  logic [SW-1:0]        tbl_rd_addr;
  pfd_pkg::slot_state_t tbl_rd_state;
  logic [PW-1:0]        tbl_rd_prio;
  logic                 tbl_wr_en;
  logic [SW-1:0]        tbl_wr_addr;
  pfd_pkg::slot_state_t tbl_wr_state;
  logic [PW-1:0]        tbl_wr_prio;

  logic [LW-1:0]        q_rd_lv;
  logic [SW-1:0]        q_head;
  logic [SW-1:0]        q_tail;
  logic [PRIORITY_LEVELS-1:0] q_nonempty;
  logic                 enq_en;
  logic [LW-1:0]        enq_lv;
  logic [SW-1:0]        enq_slot;
  logic                 deq_en;

  logic                 link_wr_en;
  logic                 link_rd_en;
  logic [SW-1:0]        link_rd_data;

  assign in_fire     = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign cur_running = (cur_state_r == pfd_pkg::ST_RUNNING);
  assign cur_lvl     = level_of(cur_prio_r);
  assign pre_lv      = level_of(pre_prio_r);

  always_comb begin
    best_lv = '0;
    q_any   = 1'b0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (q_nonempty[i]) begin
        best_lv = LW'(i);
        q_any   = 1'b1;
      end
    end
  end

  assign sel_found = q_any && (!cur_running || (best_lv < cur_lvl));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfd_pkg::S_IDLE: if (in_fire) state_nxt = pfd_pkg::S_OP;
      pfd_pkg::S_OP:   state_nxt = pfd_pkg::S_SEL;
      pfd_pkg::S_SEL:  state_nxt = sel_found ? pfd_pkg::S_DEQ : pfd_pkg::S_EMIT;
      pfd_pkg::S_DEQ:  state_nxt = preempt_r ? pfd_pkg::S_PRE : pfd_pkg::S_EMIT;
      pfd_pkg::S_PRE:  state_nxt = pfd_pkg::S_EMIT;
      pfd_pkg::S_EMIT: if (out_free) state_nxt = pfd_pkg::S_IDLE;
      default:         state_nxt = pfd_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall     = 1'b1;
    tbl_rd_en    = 1'b0;
    tbl_rd_addr  = slot_of(in_req.task_req);
    tbl_wr_en    = 1'b0;
    tbl_wr_addr  = slot_r;
    tbl_wr_state = pfd_pkg::ST_READY;
    tbl_wr_prio  = prio_r;
    q_rd_lv      = level_of(prio_r);
    enq_en       = 1'b0;
    enq_lv       = level_of(prio_r);
    enq_slot     = slot_r;
    deq_en       = 1'b0;
    link_rd_en   = 1'b0;
    status_nxt   = pfd_pkg::STS_OK;
    case (state_r)
      pfd_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        tbl_rd_en = in_fire;
      end
      pfd_pkg::S_OP: begin
        case (op_r)
          pfd_pkg::OP_ADD: begin
            if (tbl_rd_state != pfd_pkg::ST_EMPTY) begin
              status_nxt = pfd_pkg::STS_SLOT_BUSY;
            end else begin
              tbl_wr_en = 1'b1;
              enq_en    = 1'b1;
            end
          end
          pfd_pkg::OP_WAKE: begin
            tbl_wr_prio = tbl_rd_prio;
            q_rd_lv     = level_of(tbl_rd_prio);
            enq_lv      = level_of(tbl_rd_prio);
            if (tbl_rd_state != pfd_pkg::ST_BLOCKED) begin
              status_nxt = pfd_pkg::STS_BAD_STATE;
            end else begin
              tbl_wr_en = 1'b1;
              enq_en    = 1'b1;
            end
          end
          pfd_pkg::OP_BLOCK, pfd_pkg::OP_QUIT: begin
            tbl_wr_addr  = cur_r;
            tbl_wr_prio  = cur_prio_r;
            tbl_wr_state = (op_r == pfd_pkg::OP_BLOCK) ?
                           pfd_pkg::ST_BLOCKED : pfd_pkg::ST_TERMINATED;
            if (!cur_running) begin
              status_nxt = pfd_pkg::STS_BAD_STATE;
            end else begin
              tbl_wr_en = 1'b1;
            end
          end
          pfd_pkg::OP_REAP: begin
            tbl_wr_state = pfd_pkg::ST_EMPTY;
            tbl_wr_prio  = tbl_rd_prio;
            if (tbl_rd_state != pfd_pkg::ST_TERMINATED) begin
              status_nxt = pfd_pkg::STS_BAD_STATE;
            end else begin
              tbl_wr_en = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      pfd_pkg::S_SEL: begin
        q_rd_lv      = best_lv;
        tbl_rd_en    = sel_found;
        tbl_rd_addr  = q_head;
        link_rd_en   = sel_found;
        tbl_wr_en    = sel_found && cur_running;
        tbl_wr_addr  = cur_r;
        tbl_wr_state = pfd_pkg::ST_READY;
        tbl_wr_prio  = cur_prio_r;
      end
      pfd_pkg::S_DEQ: begin
        deq_en       = 1'b1;
        tbl_wr_en    = 1'b1;
        tbl_wr_addr  = deq_slot_r;
        tbl_wr_state = pfd_pkg::ST_RUNNING;
        tbl_wr_prio  = tbl_rd_prio;
      end
      pfd_pkg::S_PRE: begin
        q_rd_lv  = pre_lv;
        enq_en   = 1'b1;
        enq_lv   = pre_lv;
        enq_slot = pre_slot_r;
      end
      default: begin
      end
    endcase
  end

  assign link_wr_en = enq_en && q_nonempty[enq_lv];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfd_pkg::S_IDLE;
      cur_r       <= SW'(pfd_pkg::INIT_SLOT);
      cur_state_r <= pfd_pkg::ST_RUNNING;
      cur_prio_r  <= PW'(INIT_PRIO);
      preempt_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pfd_pkg::S_DEQ) begin
        cur_r       <= deq_slot_r;
        cur_state_r <= pfd_pkg::ST_RUNNING;
        cur_prio_r  <= tbl_rd_prio;
      end else if (tbl_wr_en && (tbl_wr_addr == cur_r)) begin
        cur_state_r <= tbl_wr_state;
        cur_prio_r  <= tbl_wr_prio;
      end
      if (state_r == pfd_pkg::S_SEL) begin
        preempt_r <= sel_found && cur_running;
      end
      if ((state_r == pfd_pkg::S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_req.operation;
      slot_r   <= slot_of(in_req.task_req);
      prio_r   <= clamp_prio(in_req.priority_req);
      before_r <= cur_r;
    end
    if (state_r == pfd_pkg::S_OP) begin
      status_r <= status_nxt;
    end
    if (state_r == pfd_pkg::S_SEL) begin
      deq_lv_r   <= best_lv;
      deq_slot_r <= q_head;
      deq_last_r <= (q_head == q_tail);
      pre_slot_r <= cur_r;
      pre_prio_r <= cur_prio_r;
    end
    if ((state_r == pfd_pkg::S_EMIT) && out_free) begin
      out_rsp_r.switched     <= (cur_r != before_r);
      out_rsp_r.running_task <= 4'(cur_r);
      out_rsp_r.idle         <= !cur_running;
      out_rsp_r.status       <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  pfd_slot_tbl #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_slot_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (tbl_rd_en),
    .rd_addr  (tbl_rd_addr),
    .rd_state (tbl_rd_state),
    .rd_prio  (tbl_rd_prio),
    .wr_en    (tbl_wr_en),
    .wr_addr  (tbl_wr_addr),
    .wr_state (tbl_wr_state),
    .wr_prio  (tbl_wr_prio)
  );

  pfd_link_ram #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (q_tail),
    .wr_data (enq_slot),
    .rd_en   (link_rd_en),
    .rd_addr (q_head),
    .rd_data (link_rd_data)
  );

  pfd_queues #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_queues (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_lv    (q_rd_lv),
    .head_rd  (q_head),
    .tail_rd  (q_tail),
    .nonempty (q_nonempty),
    .enq_en   (enq_en),
    .enq_lv   (enq_lv),
    .enq_slot (enq_slot),
    .deq_en   (deq_en),
    .deq_lv   (deq_lv_r),
    .deq_last (deq_last_r),
    .deq_next (link_rd_data)
  );

  a_pre_other_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfd_pkg::S_PRE) |-> (pre_lv != deq_lv_r))
    else $error("preempted task requeued on the dequeued level");

  a_deq_not_current: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pfd_pkg::S_DEQ) && preempt_r) |-> (deq_slot_r != cur_r))
    else $error("preemption picked the running task");

  a_tbl_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (tbl_rd_en && tbl_wr_en) |-> (tbl_rd_addr != tbl_wr_addr))
    else $error("slot table read and write hit the same entry");

  a_enq_tail_level: assert property (@(posedge clk) disable iff (!rst_n)
    enq_en |-> (q_rd_lv == enq_lv))
    else $error("enqueue link uses the tail of another level");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pfd_pkg::S_EMIT) && out_free) |=>
      (out_valid_r && (state_r == pfd_pkg::S_IDLE)))
    else $error("result not loaded on emit");

endmodule
`default_nettype wire

/* verif/task_dispatch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_dispatch_checker
// Watches both channels of the task dispatcher. Each accepted request is run
// through a local copy of the slot table and the per-priority ready queues.
// The copy yields the expected result. Each accepted result is compared field
// by field against the oldest expected one. The failure count, the number of
// results still due and the predicted slot states are handed to the top.
// ----------------------------------------------------------------------------
module task_dispatch_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pfd_pkg::req_t       in_req,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pfd_pkg::rsp_t       out_rsp,
  output int                  fail_count,
  output int                  pending,
  output logic [15:0]         empty_slots,
  output logic [15:0]         blocked_slots,
  output logic [15:0]         dead_slots
);

  localparam int NSLOT  = pfd_pkg::TASK_SLOTS_DEF;
  localparam int NLEVEL = pfd_pkg::PRIORITY_LEVELS_DEF;

  pfd_pkg::slot_state_t slot_st   [NSLOT];
  logic [2:0]           slot_prio [NSLOT];
  logic [3:0]           slot_next [NSLOT];
  logic [3:0]           lvl_head  [NLEVEL];
  logic [3:0]           lvl_tail  [NLEVEL];
  logic                 lvl_live  [NLEVEL];
  logic [3:0]           cur_slot;

  pfd_pkg::rsp_t due_results[$];
  int            mismatches = 0;

  function automatic int level_of(logic [3:0] s);
    int p;
    p = slot_prio[s];
    if (p < 1) p = 1;
    if (p > NLEVEL) p = NLEVEL;
    return p - 1;
  endfunction

  function automatic void ready_push(logic [3:0] s);
    int lv;
    lv = level_of(s);
    if (lvl_live[lv]) begin
      slot_next[lvl_tail[lv]] = s;
    end else begin
      lvl_head[lv] = s;
      lvl_live[lv] = 1'b1;
    end
    lvl_tail[lv] = s;
  endfunction

  function automatic logic [3:0] ready_pop(int lv);
    logic [3:0] s;
    s = lvl_head[lv];
    if (lvl_head[lv] == lvl_tail[lv]) begin
      lvl_live[lv] = 1'b0;
    end else begin
      lvl_head[lv] = slot_next[s];
    end
    return s;
  endfunction

  function automatic void pick_runner();
    logic [3:0] c;
    logic [3:0] nxt;
    logic       busy;
    int         lim;
    int         i;
    c    = cur_slot;
    busy = (slot_st[c] == pfd_pkg::ST_RUNNING);
    lim  = busy ? level_of(c) : NLEVEL;
    for (i = 0; i < lim; i++) begin
      if (lvl_live[i]) begin
        nxt = ready_pop(i);
        if (busy) begin
          slot_st[c] = pfd_pkg::ST_READY;
          ready_push(c);
        end
        slot_st[nxt] = pfd_pkg::ST_RUNNING;
        cur_slot     = nxt;
        return;
      end
    end
  endfunction

  function automatic void clear_table();
    int i;
    for (i = 0; i < NSLOT; i++) begin
      slot_st[i]   = pfd_pkg::ST_EMPTY;
      slot_prio[i] = '0;
      slot_next[i] = '0;
    end
    for (i = 0; i < NLEVEL; i++) begin
      lvl_head[i] = '0;
      lvl_tail[i] = '0;
      lvl_live[i] = 1'b0;
    end
    slot_st[pfd_pkg::INIT_SLOT]   = pfd_pkg::ST_RUNNING;
    slot_prio[pfd_pkg::INIT_SLOT] = 3'((NLEVEL < pfd_pkg::INIT_PRIORITY) ?
                                       NLEVEL : pfd_pkg::INIT_PRIORITY);
    cur_slot                      = 4'(pfd_pkg::INIT_SLOT);
  endfunction

  function automatic pfd_pkg::rsp_t schedule_event(pfd_pkg::req_t r);
    logic [3:0]       s;
    logic [2:0]       p;
    logic [3:0]       was;
    pfd_pkg::status_t sts;
    pfd_pkg::rsp_t    o;
    s   = r.task_req;
    p   = r.priority_req;
    was = cur_slot;
    sts = pfd_pkg::STS_OK;
    if (p < 3'd1) p = 3'd1;
    if (p > NLEVEL) p = 3'(NLEVEL);
    case (r.operation)
      pfd_pkg::OP_ADD: begin
        if (slot_st[s] != pfd_pkg::ST_EMPTY) begin
          sts = pfd_pkg::STS_SLOT_BUSY;
        end else begin
          slot_st[s]   = pfd_pkg::ST_READY;
          slot_prio[s] = p;
          ready_push(s);
        end
      end
      pfd_pkg::OP_WAKE: begin
        if (slot_st[s] != pfd_pkg::ST_BLOCKED) begin
          sts = pfd_pkg::STS_BAD_STATE;
        end else begin
          slot_st[s] = pfd_pkg::ST_READY;
          ready_push(s);
        end
      end
      pfd_pkg::OP_BLOCK: begin
        if (slot_st[cur_slot] != pfd_pkg::ST_RUNNING) sts = pfd_pkg::STS_BAD_STATE;
        else slot_st[cur_slot] = pfd_pkg::ST_BLOCKED;
      end
      pfd_pkg::OP_QUIT: begin
        if (slot_st[cur_slot] != pfd_pkg::ST_RUNNING) sts = pfd_pkg::STS_BAD_STATE;
        else slot_st[cur_slot] = pfd_pkg::ST_TERMINATED;
      end
      pfd_pkg::OP_REAP: begin
        if (slot_st[s] != pfd_pkg::ST_TERMINATED) sts = pfd_pkg::STS_BAD_STATE;
        else slot_st[s] = pfd_pkg::ST_EMPTY;
      end
      default: begin
      end
    endcase
    pick_runner();
    o.switched     = (cur_slot != was);
    o.running_task = cur_slot;
    o.idle         = (slot_st[cur_slot] != pfd_pkg::ST_RUNNING);
    o.status       = sts;
    return o;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    end
  endfunction

  initial clear_table();

  always @(posedge clk) begin
    pfd_pkg::rsp_t    want;
    logic [NSLOT-1:0] e;
    logic [NSLOT-1:0] b;
    logic [NSLOT-1:0] d;
    int               i;
    if (!rst_n) begin
      clear_table();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none due: switched=%0d task=%0d idle=%0d status=%0d",
                     $realtime, out_rsp.switched, out_rsp.running_task, out_rsp.idle,
                     out_rsp.status);
        end else begin
          want = due_results.pop_front();
          check_field("switched", want.switched, out_rsp.switched);
          check_field("running_task", want.running_task, out_rsp.running_task);
          check_field("idle", want.idle, out_rsp.idle);
          check_field("status", want.status, out_rsp.status);
        end
      end
      if (in_valid && !in_stall) due_results.push_back(schedule_event(in_req));
    end
    for (i = 0; i < NSLOT; i++) begin
      e[i] = (slot_st[i] == pfd_pkg::ST_EMPTY);
      b[i] = (slot_st[i] == pfd_pkg::ST_BLOCKED);
      d[i] = (slot_st[i] == pfd_pkg::ST_TERMINATED);
    end
    empty_slots   <= e;
    blocked_slots <= b;
    dead_slots    <= d;
    fail_count    <= mismatches;
    pending       <= due_results.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the priority FIFO task dispatcher. A directed run
// walks through every event and error case, then about 400 random requests
// follow, biased toward valid adds, wakes and reaps. Both channels idle at
// random, and once the result side holds off long enough to back up the
// request channel. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] OP_SPARE_A     = 3'd6;
  localparam logic [2:0] OP_SPARE_B     = 3'd7;
  localparam int         RANDOM_REQS    = 400;
  localparam int         LONG_HOLD_AT   = 150;
  localparam int         LONG_HOLD      = 300;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         DRAIN_CYCLES   = 12;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  pfd_pkg::req_t in_req    = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  pfd_pkg::rsp_t out_rsp;

  int          fail_count;
  int          pending;
  logic [15:0] empty_slots;
  logic [15:0] blocked_slots;
  logic [15:0] dead_slots;

  int          sent      = 0;
  int          rsp_count = 0;
  int          quiet     = 0;
  int          stall_left = 0;
  int          rx_cycle  = 0;
  logic        long_hold_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  priority_fifo_task_dispatcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  task_dispatch_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rsp       (out_rsp),
    .fail_count    (fail_count),
    .pending       (pending),
    .empty_slots   (empty_slots),
    .blocked_slots (blocked_slots),
    .dead_slots    (dead_slots)
  );

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] pick_slot(logic [15:0] pool);
    int n;
    int k;
    int i;
    n = $countones(pool);
    if (n == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    k = $urandom_range(0, n - 1);
    for (i = 0; i < 16; i++) begin
      if (pool[i]) begin
        if (k == 0) return 4'(i);
        k--;
      end
    end
    return '0;
  endfunction

  task automatic send_req(input logic [2:0] op, input logic [3:0] slot, input logic [2:0] pr);
    pfd_pkg::req_t r;
    int            gap;
    r.operation    = op;
    r.task_req     = slot;
    r.priority_req = pr;
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = (sent % 80 < 20) ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int         w;
    logic [2:0] op;
    logic [3:0] slot;
    logic [2:0] pr;
    w    = $urandom_range(0, 99);
    slot = 4'($urandom_range(0, 15));
    pr   = 3'($urandom_range(0, 7));
    if (w < 28) begin
      op   = pfd_pkg::OP_ADD;
      slot = pick_slot(empty_slots);
    end else if (w < 44) begin
      op   = pfd_pkg::OP_WAKE;
      slot = pick_slot(blocked_slots);
    end else if (w < 58) begin
      op = pfd_pkg::OP_BLOCK;
    end else if (w < 70) begin
      op = pfd_pkg::OP_QUIT;
    end else if (w < 84) begin
      op = pfd_pkg::OP_TICK;
    end else if (w < 96) begin
      op   = pfd_pkg::OP_REAP;
      slot = pick_slot(dead_slots);
    end else begin
      op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end
    send_req(op, slot, pr);
  endtask

  // receiver: random stalls, calm stretches, one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      rx_cycle <= rx_cycle + 1;
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!long_hold_done && rsp_count >= LONG_HOLD_AT) begin
        out_stall      <= 1'b1;
        stall_left     <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (rx_cycle % 1024 >= 768 || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall  <= 1'b1;
        stall_left <= idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) rsp_count <= rsp_count + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(pfd_pkg::OP_TICK, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_ADD, 4'd2, 3'd0);
    send_req(pfd_pkg::OP_ADD, 4'd2, 3'd3);
    send_req(pfd_pkg::OP_ADD, 4'd15, 3'd7);
    send_req(pfd_pkg::OP_ADD, 4'd3, 3'd1);
    send_req(pfd_pkg::OP_WAKE, 4'd4, 3'd0);
    send_req(pfd_pkg::OP_REAP, 4'd1, 3'd0);
    send_req(pfd_pkg::OP_TICK, 4'd0, 3'd7);
    send_req(pfd_pkg::OP_BLOCK, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_WAKE, 4'd2, 3'd0);
    send_req(pfd_pkg::OP_QUIT, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_REAP, 4'd3, 3'd0);
    send_req(pfd_pkg::OP_QUIT, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_QUIT, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_BLOCK, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_BLOCK, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_QUIT, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_TICK, 4'd15, 3'd7);
    send_req(pfd_pkg::OP_WAKE, 4'd15, 3'd0);
    send_req(pfd_pkg::OP_QUIT, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_REAP, 4'd15, 3'd0);
    send_req(OP_SPARE_A, 4'd15, 3'd7);
    send_req(OP_SPARE_B, 4'd0, 3'd0);
    send_req(pfd_pkg::OP_ADD, 4'd15, 3'd5);
    send_req(pfd_pkg::OP_ADD, 4'd0, 3'd7);

    for (i = 0; i < RANDOM_REQS; i++) send_random();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
